[rtl/ttra_pkg.sv]
// shared types, constants and helpers for the tiled texture row address generator
// no dependencies; imported by every module of the block
`default_nettype none

package ttra_pkg;

  localparam int ADDR_W = 25;

  // configuration register indexes
  localparam logic [2:0] CFG_PIXEL_SIZE  = 3'd0;
  localparam logic [2:0] CFG_TILING_MODE = 3'd1;
  localparam logic [2:0] CFG_IMAGE_COLS  = 3'd2;
  localparam logic [2:0] CFG_TILED_PITCH = 3'd3;
  localparam logic [2:0] CFG_LIN_PITCH   = 3'd4;
  localparam logic [2:0] CFG_ORIGIN_COL  = 3'd5;
  localparam logic [2:0] CFG_ORIGIN_ROW  = 3'd6;

  // pixel size code for one byte per pixel (the only 8-row microtile)
  localparam logic [1:0] PIX_1B = 2'd0;

  localparam logic       MODE_LT = 1'b0;
  localparam logic       MODE_T  = 1'b1;

  localparam logic [4:0] ROW_BYTES_TALL  = 5'd8;
  localparam logic [4:0] ROW_BYTES_SHORT = 5'd16;

  // subtile order inside a 4k tile, by tile row parity
  localparam logic [1:0] ODD_ORDER  [4] = '{2'd2, 2'd1, 2'd3, 2'd0};
  localparam logic [1:0] EVEN_ORDER [4] = '{2'd0, 2'd3, 2'd1, 2'd2};

  typedef struct packed {
    logic [9:0] utile_col;
    logic [9:0] utile_row;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] tiled_address;
    logic [ADDR_W-1:0] linear_address;
    logic [4:0]        row_bytes;
    logic              last_row;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  pixel_size_code;
    logic        tiling_mode;
    logic [10:0] image_utile_columns;
    logic [14:0] tiled_row_pitch;
    logic [14:0] linear_row_pitch;
    logic [9:0]  box_origin_col;
    logic [9:0]  box_origin_row;
  } cfg_t;

  // start of one microtile as handed to the row generator
  typedef struct packed {
    logic [ADDR_W-1:0] tbase;
    logic [ADDR_W-1:0] lbase;
    logic [14:0]       lstep;
    logic              tall;
  } base_t;

  function automatic logic [1:0] sub_order(input logic odd, input logic [1:0] sidx);
    sub_order = odd ? ODD_ORDER[sidx] : EVEN_ORDER[sidx];
  endfunction

endpackage

`default_nettype wire

[rtl/tiled_texture_row_address_gen.sv]
// top level of the tiled texture row address generator: config registers, input register
// depends on ttra_pkg, ttra_base, ttra_row_gen
`default_nettype none

// usage
//   in channel (in_valid/in_ready/in_data): one microtile position inside the box
//   out channel (out_valid/out_ready/out_data): one transfer per pixel row of that
//     microtile, 8 rows at one byte per pixel, 4 rows otherwise, last_row on the final one
//   cfg port: cfg_wr_en/cfg_index/cfg_wr_data, a write lands on the clock edge; the user must
//     write only while no item is in flight, the block itself does not enforce it
// an item is registered in the input register on its transfer; its first row is loaded
//   into the result register when the row generator takes the item from there
// throughput: one row per cycle while out_ready is high; the row generator
//   reloads on the same edge that its final row is taken, so rows of consecutive
//   items follow without a gap
// the input register accepts a new item while the row generator is busy with the
//   previous one; in_ready drops only when both are occupied
// reset: synchronous active low, registers return to pixel size code 2, T mode, an 8-column
//   image, zero pitches and zero box origin; both stages empty
// a stalled receiver holds the current row steady; the input side fills and then
//   backs up through in_ready
module tiled_texture_row_address_gen (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ttra_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ttra_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [14:0]         cfg_wr_data
);
  import ttra_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     s0_valid_r;
  logic     s0_valid_nxt;
  in_item_t s0_item_r;
  in_item_t s0_item_nxt;
  base_t    base;
  logic     base_take;

  // config register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PIXEL_SIZE:  cfg_nxt.pixel_size_code     = cfg_wr_data[1:0];
        CFG_TILING_MODE: cfg_nxt.tiling_mode         = cfg_wr_data[0];
        CFG_IMAGE_COLS:  cfg_nxt.image_utile_columns = cfg_wr_data[10:0];
        CFG_TILED_PITCH: cfg_nxt.tiled_row_pitch     = cfg_wr_data;
        CFG_LIN_PITCH:   cfg_nxt.linear_row_pitch    = cfg_wr_data;
        CFG_ORIGIN_COL:  cfg_nxt.box_origin_col      = cfg_wr_data[9:0];
        CFG_ORIGIN_ROW:  cfg_nxt.box_origin_row      = cfg_wr_data[9:0];
        default: ;  // unmapped index, write ignored
      endcase
    end
  end

  // input register: refills on the cycle its item moves to the row generator
  assign in_ready = !s0_valid_r || base_take;

  always_comb begin
    s0_valid_nxt = s0_valid_r && !base_take;
    s0_item_nxt  = s0_item_r;
    if (in_valid && in_ready) begin
      s0_valid_nxt = 1'b1;
      s0_item_nxt  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_size_code     <= 2'd2;
      cfg_r.tiling_mode         <= MODE_T;
      cfg_r.image_utile_columns <= 11'd8;
      cfg_r.tiled_row_pitch     <= 15'd0;
      cfg_r.linear_row_pitch    <= 15'd0;
      cfg_r.box_origin_col      <= 10'd0;
      cfg_r.box_origin_row      <= 10'd0;
      s0_valid_r                <= 1'b0;
    end else begin
      cfg_r      <= cfg_nxt;
      s0_valid_r <= s0_valid_nxt;
    end
    s0_item_r <= s0_item_nxt;
  end

  // base addresses of the held microtile, one multiply deep
  ttra_base u_base (
    .cfg  (cfg_r),
    .item (s0_item_r),
    .base (base)
  );

  // per-row stepping and the result register
  ttra_row_gen u_row_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .base_valid (s0_valid_r),
    .base       (base),
    .base_take  (base_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

[rtl/ttra_base.sv]
// microtile base address calculation for T and LT layouts and the linear buffer
// depends on ttra_pkg
`default_nettype none

module ttra_base (
  input  ttra_pkg::cfg_t     cfg,
  input  ttra_pkg::in_item_t item,
  output ttra_pkg::base_t    base
);
  import ttra_pkg::*;

  logic              tall;
  logic [9:0]        acol;
  logic [9:0]        arow;
  logic [7:0]        tiles_per_row;
  logic [6:0]        tx;
  logic [6:0]        ty;
  logic              odd;
  logic [12:0]       tx_sel;
  logic [14:0]       ty_x_tpr;
  logic [12:0]       tile_idx;
  logic [1:0]        sub;
  logic [ADDR_W-1:0] t_addr;
  logic [ADDR_W-1:0] lt_prod;
  logic [ADDR_W-1:0] lt_addr;
  logic [ADDR_W-1:0] ln_prod;
  logic [ADDR_W-1:0] ln_addr;

  assign tall = (cfg.pixel_size_code == PIX_1B);
  assign acol = cfg.box_origin_col + item.utile_col;
  assign arow = cfg.box_origin_row + item.utile_row;

  // T layout: tile index, subtile order, 4x4 raster of microtiles
  assign tiles_per_row = cfg.image_utile_columns[10:3];
  assign tx  = acol[9:3];
  assign ty  = arow[9:3];
  assign odd = ty[0];
  // odd tile rows run right to left
  assign tx_sel   = odd ? (13'(tiles_per_row) - 13'(tx) - 13'd1) : 13'(tx);
  assign ty_x_tpr = 15'(ty) * 15'(tiles_per_row);
  assign tile_idx = ty_x_tpr[12:0] + tx_sel;
  assign sub      = sub_order(odd, {arow[2], acol[2]});
  assign t_addr   = {tile_idx, sub, arow[1:0], acol[1:0], 6'b0};

  // LT layout: plain raster of microtiles
  assign lt_prod = 25'(arow) * 25'(cfg.tiled_row_pitch);
  assign lt_addr = (tall ? (lt_prod << 3) : (lt_prod << 2)) + 25'({acol, 6'b0});

  // linear buffer, box-relative coordinates
  assign ln_prod = 25'(item.utile_row) * 25'(cfg.linear_row_pitch);
  assign ln_addr = (tall ? (ln_prod << 3) : (ln_prod << 2))
                 + (tall ? 25'({item.utile_col, 3'b0}) : 25'({item.utile_col, 4'b0}));

  always_comb begin
    base.tbase = (cfg.tiling_mode == MODE_T) ? t_addr : lt_addr;
    base.lbase = ln_addr;
    base.lstep = cfg.linear_row_pitch;
    base.tall  = tall;
  end

endmodule

`default_nettype wire

[rtl/ttra_row_gen.sv]
// row generator: steps through the pixel rows of one microtile, holds the result register
// depends on ttra_pkg
`default_nettype none

module ttra_row_gen (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                base_valid,
  input  ttra_pkg::base_t     base,
  output logic                base_take,
  output logic                out_valid,
  input  logic                out_ready,
  output ttra_pkg::out_item_t out_data
);
  import ttra_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [ADDR_W-1:0] tacc_r;
  logic [ADDR_W-1:0] tacc_nxt;
  logic [ADDR_W-1:0] lacc_r;
  logic [ADDR_W-1:0] lacc_nxt;
  logic [14:0]       lstep_r;
  logic [14:0]       lstep_nxt;
  logic              tall_r;
  logic              tall_nxt;
  logic [2:0]        row_r;
  logic [2:0]        row_nxt;
  logic              last;
  logic              advance;
  logic              load;
  logic [4:0]        rbytes;

  assign last    = tall_r ? (row_r == 3'd7) : (row_r == 3'd3);
  assign rbytes  = tall_r ? ROW_BYTES_TALL : ROW_BYTES_SHORT;
  assign advance = !valid_r || out_ready;
  assign load    = advance && (!valid_r || last);
  assign base_take = load && base_valid;

  always_comb begin
    valid_nxt = valid_r;
    tacc_nxt  = tacc_r;
    lacc_nxt  = lacc_r;
    lstep_nxt = lstep_r;
    tall_nxt  = tall_r;
    row_nxt   = row_r;
    if (load) begin
      valid_nxt = base_valid;
      tacc_nxt  = base.tbase;
      lacc_nxt  = base.lbase;
      lstep_nxt = base.lstep;
      tall_nxt  = base.tall;
      row_nxt   = 3'd0;
    end else if (advance) begin
      tacc_nxt = tacc_r + 25'(rbytes);
      lacc_nxt = lacc_r + 25'(lstep_r);
      row_nxt  = row_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      row_r   <= 3'd0;
      tall_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      row_r   <= row_nxt;
      tall_r  <= tall_nxt;
    end
    tacc_r  <= tacc_nxt;
    lacc_r  <= lacc_nxt;
    lstep_r <= lstep_nxt;
  end

  assign out_valid = valid_r;
  always_comb begin
    out_data.tiled_address  = tacc_r;
    out_data.linear_address = lacc_r;
    out_data.row_bytes      = rbytes;
    out_data.last_row       = last;
  end

endmodule

`default_nettype wire

[rtl/ttra_checker.sv]
// port-level checks for the tiled texture row address generator, bound to the top level
// depends on ttra_pkg and tiled_texture_row_address_gen
`default_nettype none

module ttra_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input ttra_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input ttra_pkg::out_item_t out_data,
  input logic                cfg_wr_en,
  input logic [2:0]          cfg_index,
  input logic [14:0]         cfg_wr_data
);
  import ttra_pkg::*;

  // result register empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a held row stays put while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // rows of one microtile follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_row |=>
      out_valid && out_data.row_bytes == $past(out_data.row_bytes))
    else $error("gap or size change inside a microtile");

  // tiled address steps by one row length within a microtile
  a_tiled_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_row |=>
      out_data.tiled_address ==
        ADDR_W'($past(out_data.tiled_address) + ADDR_W'($past(out_data.row_bytes))))
    else $error("tiled address did not advance by row length");

  // row length is always 8 or 16 bytes
  a_row_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.row_bytes == ROW_BYTES_TALL ||
                  out_data.row_bytes == ROW_BYTES_SHORT)
    else $error("bad row length");

endmodule

bind tiled_texture_row_address_gen ttra_checker u_ttra_checker (.*);

`default_nettype wire
